// ===== hw/rtl/nop_pkg.sv =====
package nop_pkg;

   localparam int OPEN_SLOTS = 32;
   localparam int INDEX_BITS = 16;

   localparam int PITCH_W = 7;
   localparam int TIME_W  = 32;
   localparam int NIDX_W  = 16;
   localparam int STAT_W  = 2;

   typedef enum logic [STAT_W-1:0] {
      ST_OPENED    = 2'd0,
      ST_CLOSED    = 2'd1,
      ST_UNMATCHED = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam logic OP_NOTE_OFF = 1'b0;
   localparam logic OP_NOTE_ON  = 1'b1;

   typedef struct packed {
      logic capture;
      logic update;
      logic finish;
   } nop_cmd_type;

endpackage

// ===== hw/rtl/nop_req_if.sv =====
interface nop_req_if;
   import nop_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [PITCH_W-1:0]   pitch;
   logic [TIME_W-1:0]    event_time;

   modport source (output valid, output operation, output pitch, output event_time,
                   input ready);
   modport sink   (input valid, input operation, input pitch, input event_time,
                   output ready);
endinterface

// ===== hw/rtl/nop_rsp_if.sv =====
interface nop_rsp_if;
   import nop_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [NIDX_W-1:0]    note_index;
   logic [PITCH_W-1:0]   note_pitch;
   logic [TIME_W-1:0]    duration;

   modport source (output valid, output status, output note_index, output note_pitch,
                   output duration, input ready);
   modport sink   (input valid, input status, input note_index, input note_pitch,
                   input duration, output ready);
endinterface

// ===== hw/rtl/nop_ctrl.sv =====
module nop_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nop_pkg::nop_cmd_type cmd
);
   import nop_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_FINISH,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= S_MATCH;
               end
            end
            S_MATCH: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready   = req_ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = req_valid && req_ready_ff;
   assign cmd.update  = (state_ff == S_MATCH);
   assign cmd.finish  = (state_ff == S_FINISH);

endmodule

// ===== hw/rtl/nop_dpath.sv =====
module nop_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  nop_pkg::nop_cmd_type          cmd,
   input  logic                          req_operation,
   input  logic [nop_pkg::PITCH_W-1:0]   req_pitch,
   input  logic [nop_pkg::TIME_W-1:0]    req_event_time,
   output logic [nop_pkg::STAT_W-1:0]    rsp_status,
   output logic [nop_pkg::NIDX_W-1:0]    rsp_note_index,
   output logic [nop_pkg::PITCH_W-1:0]   rsp_note_pitch,
   output logic [nop_pkg::TIME_W-1:0]    rsp_duration
);
   import nop_pkg::*;

   // captured transaction
   logic                  op_ff;
   logic [PITCH_W-1:0]    pitch_ff;
   logic [TIME_W-1:0]     time_ff;

   // compacting chain of open notes, oldest in slot 0
   logic [OPEN_SLOTS-1:0] valid_ff;
   logic [PITCH_W-1:0]    slot_pitch_ff [OPEN_SLOTS];
   logic [INDEX_BITS-1:0] slot_index_ff [OPEN_SLOTS];
   logic [TIME_W-1:0]     slot_start_ff [OPEN_SLOTS];

   logic [INDEX_BITS-1:0] next_index_ff;

   // match stage results
   status_type            status_ff;
   logic [INDEX_BITS-1:0] sel_index_ff;
   logic [TIME_W-1:0]     sel_start_ff;

   // response registers
   logic [STAT_W-1:0]     out_status_ff;
   logic [NIDX_W-1:0]     out_index_ff;
   logic [PITCH_W-1:0]    out_pitch_ff;
   logic [TIME_W-1:0]     out_duration_ff;

   logic [OPEN_SLOTS-1:0] hit;
   logic [OPEN_SLOTS-1:0] first_hit;
   logic [OPEN_SLOTS-1:0] shift_mask;
   logic [OPEN_SLOTS-1:0] free;
   logic [OPEN_SLOTS-1:0] first_free;
   logic                  table_full;
   logic                  any_hit;
   logic [INDEX_BITS-1:0] hit_index;
   logic [TIME_W-1:0]     hit_start;
   logic [TIME_W:0]       diff;

   always_comb begin
      for (int k = 0; k < OPEN_SLOTS; k++) begin
         hit[k] = valid_ff[k] && (slot_pitch_ff[k] == pitch_ff);
      end
      first_hit  = hit & (~hit + 1'b1);
      shift_mask = ~(first_hit - 1'b1);
      free       = ~valid_ff;
      first_free = free & (~free + 1'b1);
      table_full = &valid_ff;
      any_hit    = |hit;
      hit_index  = '0;
      hit_start  = '0;
      for (int k = 0; k < OPEN_SLOTS; k++) begin
         hit_index = hit_index | ({INDEX_BITS{first_hit[k]}} & slot_index_ff[k]);
         hit_start = hit_start | ({TIME_W{first_hit[k]}} & slot_start_ff[k]);
      end
   end

   assign diff = {1'b0, time_ff} - {1'b0, sel_start_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         pitch_ff <= req_pitch;
         time_ff  <= req_event_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         next_index_ff <= '0;
      end else if (cmd.update) begin
         if (op_ff == OP_NOTE_ON) begin
            next_index_ff <= next_index_ff + 1'b1;
            valid_ff      <= valid_ff | first_free;
         end else if (any_hit) begin
            for (int k = 0; k < OPEN_SLOTS; k++) begin
               if (shift_mask[k]) begin
                  if (k + 1 < OPEN_SLOTS) begin
                     valid_ff[k] <= valid_ff[(k + 1) % OPEN_SLOTS];
                  end else begin
                     valid_ff[k] <= 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int k = 0; k < OPEN_SLOTS; k++) begin
            if (op_ff == OP_NOTE_ON) begin
               if (first_free[k]) begin
                  slot_pitch_ff[k] <= pitch_ff;
                  slot_index_ff[k] <= next_index_ff;
                  slot_start_ff[k] <= time_ff;
               end
            end else if (shift_mask[k] && (k + 1 < OPEN_SLOTS)) begin
               slot_pitch_ff[k] <= slot_pitch_ff[(k + 1) % OPEN_SLOTS];
               slot_index_ff[k] <= slot_index_ff[(k + 1) % OPEN_SLOTS];
               slot_start_ff[k] <= slot_start_ff[(k + 1) % OPEN_SLOTS];
            end
         end
         if (op_ff == OP_NOTE_ON) begin
            status_ff    <= table_full ? ST_FULL : ST_OPENED;
            sel_index_ff <= next_index_ff;
            sel_start_ff <= time_ff;
         end else if (any_hit) begin
            status_ff    <= ST_CLOSED;
            sel_index_ff <= hit_index;
            sel_start_ff <= hit_start;
         end else begin
            status_ff    <= ST_UNMATCHED;
            sel_index_ff <= '0;
            sel_start_ff <= time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_status_ff <= status_ff;
         out_index_ff  <= NIDX_W'(sel_index_ff);
         out_pitch_ff  <= pitch_ff;
         if (status_ff == ST_CLOSED && !diff[TIME_W]) begin
            out_duration_ff <= diff[TIME_W-1:0];
         end else begin
            out_duration_ff <= '0;
         end
      end
   end

   assign rsp_status     = out_status_ff;
   assign rsp_note_index = out_index_ff;
   assign rsp_note_pitch = out_pitch_ff;
   assign rsp_duration   = out_duration_ff;

endmodule

// ===== hw/rtl/note_on_off_pairing_top.sv =====
// An accepted request passes the match state and then the finish state; rsp valid
// is then raised from a register and held until the response is taken.
// One transaction at a time: the next request waits for the response handshake. The
// match-and-compact step over the open-note chain runs in the match state, and the
// duration subtract runs in the finish state.
// Reset (synchronous, active high) empties the open-note table and zeroes the
// note index counter; no clearing pass is needed.
module note_on_off_pairing_top (
   input  logic      clock,
   input  logic      reset,
   nop_req_if.sink   req_chan,
   nop_rsp_if.source rsp_chan
);
   import nop_pkg::*;

   nop_cmd_type cmd;

   nop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   nop_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_chan.operation),
      .req_pitch      (req_chan.pitch),
      .req_event_time (req_chan.event_time),
      .rsp_status     (rsp_chan.status),
      .rsp_note_index (rsp_chan.note_index),
      .rsp_note_pitch (rsp_chan.note_pitch),
      .rsp_duration   (rsp_chan.duration)
   );

endmodule
